// ===== rtl/core/ptd_pkg.sv =====
// ptd_pkg: shared types, register indexes and constants of the point transform
// depends on nothing; imported by every module of the block
package ptd_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_OPERATION = 3'd0;
  localparam logic [2:0] REG_AXIS_SEL  = 3'd1;
  localparam logic [2:0] REG_ANGLE     = 3'd2;
  localparam logic [2:0] REG_AMOUNT    = 3'd3;
  localparam logic [2:0] REG_AXIS_UX   = 3'd4;
  localparam logic [2:0] REG_AXIS_UY   = 3'd5;
  localparam logic [2:0] REG_AXIS_UZ   = 3'd6;

  // operation codes
  localparam logic [2:0] OP_ROT_AXIS  = 3'd0;
  localparam logic [2:0] OP_ROT_PRIN  = 3'd1;
  localparam logic [2:0] OP_TRANSLATE = 3'd2;
  localparam logic [2:0] OP_MIRROR    = 3'd3;
  localparam logic [2:0] OP_SCALE     = 3'd4;

  // axis codes
  localparam logic [1:0] AX_X    = 2'd0;
  localparam logic [1:0] AX_Y    = 2'd1;
  localparam logic [1:0] AX_Z    = 2'd2;
  localparam logic [1:0] AX_NONE = 2'd3;

  localparam int ATAN_ENTRIES = 24;
  localparam int TRIG_W       = 34;
  localparam int Z_W          = 35;
  localparam int ENT_W        = 41;
  localparam int MAT_W        = 32;

  localparam logic signed [Z_W-1:0] Q30_ONE     = 35'sd1073741824;
  localparam logic signed [Z_W-1:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [Z_W-1:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [TRIG_W-1:0] GAIN_INV = 34'sd652032874;

  // per-lane operation
  typedef enum logic [2:0] {
    MODE_PASS = 3'd0,
    MODE_ROT  = 3'd1,
    MODE_ADD  = 3'd2,
    MODE_NEG  = 3'd3,
    MODE_MUL  = 3'd4
  } mode_t;

  // sine and cosine handed from the cordic to the matrix builder
  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
  } trig_t;

  // truncated atan(2^-i) in q30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314856;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043836;
      5'd3:  r = 30'd133525158;
      5'd4:  r = 30'd67021686;
      5'd5:  r = 30'd33543515;
      5'd6:  r = 30'd16775850;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194282;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048575;
      5'd11: r = 30'd524287;
      5'd12: r = 30'd262143;
      5'd13: r = 30'd131071;
      5'd14: r = 30'd65535;
      5'd15: r = 30'd32767;
      5'd16: r = 30'd16383;
      5'd17: r = 30'd8191;
      5'd18: r = 30'd4095;
      5'd19: r = 30'd2047;
      5'd20: r = 30'd1023;
      5'd21: r = 30'd511;
      5'd22: r = 30'd255;
      5'd23: r = 30'd127;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // clamp a matrix entry to [-1, +1] in q30
  function automatic logic signed [MAT_W-1:0] clamp_ent(input logic signed [ENT_W-1:0] v);
    logic signed [MAT_W-1:0] r;
    if (v > ENT_W'(Q30_ONE)) begin
      r = MAT_W'(Q30_ONE);
    end else if (v < -ENT_W'(Q30_ONE)) begin
      r = -MAT_W'(Q30_ONE);
    end else begin
      r = MAT_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ptd_cordic.sv =====
// ptd_cordic: iterative rotation-mode cordic, one step per cycle
// depends on ptd_pkg
module ptd_cordic #(
  parameter int STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [15:0]   angle,
  output ptd_pkg::trig_t       trig
);
  import ptd_pkg::*;

  localparam int N = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;

  logic                     busy;
  logic                     done;
  logic                     neg;
  logic [4:0]               cnt;
  logic signed [TRIG_W-1:0] x;
  logic signed [TRIG_W-1:0] y;
  logic signed [Z_W-1:0]    z;
  logic signed [Z_W-1:0]    z0;
  logic signed [TRIG_W-1:0] dx;
  logic signed [TRIG_W-1:0] dy;
  logic signed [Z_W-1:0]    da;

  assign z0 = {{2{angle[15]}}, angle, 17'd0};
  assign dx = y >>> cnt;
  assign dy = x >>> cnt;
  assign da = Z_W'({5'd0, atan_q30(cnt)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      x    <= GAIN_INV;
      y    <= '0;
      // fold into [-pi/2, pi/2], sign flip at the end
      if (z0 > Q30_HALF_PI) begin
        z   <= z0 - Q30_PI;
        neg <= 1'b1;
      end else if (z0 < -Q30_HALF_PI) begin
        z   <= z0 + Q30_PI;
        neg <= 1'b1;
      end else begin
        z   <= z0;
        neg <= 1'b0;
      end
    end else if (busy) begin
      if (!z[Z_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - da;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + da;
      end
      cnt <= cnt + 5'd1;
      if (cnt == 5'(N - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign trig.done = done;
  assign trig.c    = neg ? -x : x;
  assign trig.s    = neg ? -y : y;

endmodule

// ===== rtl/core/ptd_matrix.sv =====
// ptd_matrix: rebuilds the clamped q30 rotation matrix after reset or a register write
// depends on ptd_pkg and ptd_cordic
module ptd_matrix #(
  parameter int STEPS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      kick,
  input  logic [2:0]                operation,
  input  logic [1:0]                axis_select,
  input  logic signed [15:0]        angle,
  input  logic signed [15:0]        axis_ux,
  input  logic signed [15:0]        axis_uy,
  input  logic signed [15:0]        axis_uz,
  output logic                      ready,
  output logic signed [ptd_pkg::MAT_W-1:0] mat [9]
);
  import ptd_pkg::*;

  typedef enum logic [4:0] {
    ST_START = 5'b00001,
    ST_TRIG  = 5'b00010,
    ST_UU    = 5'b00100,
    ST_TP    = 5'b01000,
    ST_BUILD = 5'b10000
  } mst_t;

  mst_t                     state;
  logic                     rdy;
  logic [2:0]               k;
  trig_t                    trig;
  logic signed [TRIG_W-1:0] c;
  logic signed [TRIG_W-1:0] s;
  logic signed [31:0]       uu [6];
  logic signed [35:0]       us [3];
  logic signed [38:0]       tt [6];
  logic signed [Z_W-1:0]    t;
  logic signed [66:0]       p_tt;
  logic signed [49:0]       p_us [3];
  logic signed [15:0]       u [3];
  logic signed [ENT_W-1:0]  m [9];
  logic signed [ENT_W-1:0]  ce;
  logic signed [ENT_W-1:0]  se;
  logic signed [ENT_W-1:0]  one;

  ptd_cordic #(.STEPS(STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_START),
    .angle (angle),
    .trig  (trig)
  );

  assign u[0] = axis_ux;
  assign u[1] = axis_uy;
  assign u[2] = axis_uz;
  assign t    = Q30_ONE - Z_W'(c);
  assign p_tt = uu[k] * t;
  assign ce   = ENT_W'(c);
  assign se   = ENT_W'(s);
  assign one  = ENT_W'(Q30_ONE);

  for (genvar g = 0; g < 3; g++) begin : g_us
    assign p_us[g] = u[g] * s;
  end

  always_comb begin
    for (int n = 0; n < 9; n++) begin
      m[n] = '0;
    end
    if (operation == OP_ROT_AXIS) begin
      m[0] = ENT_W'(tt[0]) + ce;
      m[4] = ENT_W'(tt[1]) + ce;
      m[8] = ENT_W'(tt[2]) + ce;
      m[1] = ENT_W'(tt[3]) - ENT_W'(us[2]);
      m[3] = ENT_W'(tt[3]) + ENT_W'(us[2]);
      m[2] = ENT_W'(tt[4]) + ENT_W'(us[1]);
      m[6] = ENT_W'(tt[4]) - ENT_W'(us[1]);
      m[5] = ENT_W'(tt[5]) - ENT_W'(us[0]);
      m[7] = ENT_W'(tt[5]) + ENT_W'(us[0]);
    end else begin
      // principal axis rotation
      unique case (axis_select)
        AX_X: begin
          m[0] = one; m[4] = ce; m[8] = ce; m[5] = -se; m[7] = se;
        end
        AX_Y: begin
          m[4] = one; m[8] = ce; m[0] = ce; m[6] = -se; m[2] = se;
        end
        AX_Z: begin
          m[8] = one; m[0] = ce; m[4] = ce; m[1] = -se; m[3] = se;
        end
        default: begin
          m[0] = one; m[4] = one; m[8] = one;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START;
      rdy   <= 1'b0;
    end else if (kick) begin
      state <= ST_START;
      rdy   <= 1'b0;
    end else begin
      unique case (state)
        ST_START: state <= ST_TRIG;
        ST_TRIG: begin
          if (trig.done) begin
            c     <= trig.c;
            s     <= trig.s;
            state <= ST_UU;
          end
        end
        ST_UU: begin
          uu[0] <= u[0] * u[0];
          uu[1] <= u[1] * u[1];
          uu[2] <= u[2] * u[2];
          uu[3] <= u[0] * u[1];
          uu[4] <= u[0] * u[2];
          uu[5] <= u[1] * u[2];
          for (int n = 0; n < 3; n++) begin
            us[n] <= 36'(p_us[n] >>> 14);
          end
          k     <= '0;
          state <= ST_TP;
        end
        ST_TP: begin
          tt[k] <= 39'(p_tt >>> 28);
          k     <= k + 3'd1;
          if (k == 3'd5) begin
            state <= ST_BUILD;
          end
        end
        ST_BUILD: begin
          for (int n = 0; n < 9; n++) begin
            mat[n] <= clamp_ent(m[n]);
          end
          rdy <= 1'b1;
        end
        default: state <= ST_START;
      endcase
    end
  end

  assign ready = rdy;

endmodule

// ===== rtl/core/ptd_lane.sv =====
// ptd_lane: one coordinate row; products in the first stage, sum and saturation after
// depends on ptd_pkg
module ptd_lane #(
  parameter int W = 32
) (
  input  logic                          clk,
  input  logic                          en,
  input  ptd_pkg::mode_t                mode,
  input  logic signed [ptd_pkg::MAT_W-1:0] row [3],
  input  logic signed [W-1:0]           p [3],
  input  logic signed [W-1:0]           p_self,
  input  logic signed [31:0]            amount,
  output logic signed [W-1:0]           q,
  output logic                          ovf
);
  import ptd_pkg::*;

  localparam int MF = ((62 - W) < 30) ? (62 - W) : 30;
  localparam int PW = W + 32;
  localparam int VW = W + 34;

  mode_t               mode_r;
  logic signed [W-1:0] p_r;
  logic signed [PW-1:0] prod [3];
  logic signed [31:0]  b [3];
  logic signed [VW-1:0] sum;
  logic signed [VW-1:0] v;
  logic [VW-W:0]       hi;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      b[j] = row[j] >>> (30 - MF);
    end
    if (mode == MODE_MUL) begin
      b[0] = amount;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_r <= mode;
      p_r    <= p_self;
      if (mode == MODE_MUL) begin
        // scaling needs only the first product
        prod[0] <= p_self * b[0];
        prod[1] <= '0;
        prod[2] <= '0;
      end else begin
        for (int j = 0; j < 3; j++) begin
          prod[j] <= p[j] * b[j];
        end
      end
    end
  end

  assign sum = VW'(prod[0]) + VW'(prod[1]) + VW'(prod[2]);

  always_comb begin
    case (mode_r)
      MODE_ROT: v = sum >>> MF;
      MODE_MUL: v = VW'(prod[0]) >>> 16;
      MODE_ADD: v = VW'(p_r) + VW'(amount);
      MODE_NEG: v = -VW'(p_r);
      default:  v = VW'(p_r);
    endcase
  end

  assign hi = v[VW-1:W-1];

  always_comb begin
    if (&hi || ~|hi) begin
      q   = v[W-1:0];
      ovf = 1'b0;
    end else begin
      q   = v[VW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      ovf = 1'b1;
    end
  end

endmodule

// ===== rtl/core/point_transform_3d.sv =====
// point_transform_3d: rotates, translates, mirrors or scales a stream of 3d points
// depends on ptd_pkg, ptd_matrix (with ptd_cordic) and ptd_lane
//
//   channel   | direction | payload
//   s_*       | in        | s_tdata: px, py, pz
//   m_*       | out       | m_tdata: qx, qy, qz, overflow
//   cfg_*     | in        | cfg_idx selects register, cfg_data value
//
// one item per cycle while the output is taken and no rebuild runs; an item passes
// the lane product register, then the output register; after reset and every
// register write the matrix builder runs cordic steps, then six shared multiplies;
// s_tready is low then; the whole pipe advances when the output register is empty or taken
// rst is synchronous and active high
module point_transform_3d #(
  parameter int COORD_WIDTH  = 32,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,  // px, py, pz from lsb
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [((3*COORD_WIDTH+8)/8)*8-1:0]   m_tdata,  // qx, qy, qz, overflow from lsb
  input  logic                cfg_wen,
  input  logic [2:0]          cfg_idx,
  input  logic [31:0]         cfg_data
);
  import ptd_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int OUT_W = ((3 * W + 8) / 8) * 8;

  // configuration registers
  logic [2:0]         operation;
  logic [1:0]         axis_select;
  logic signed [15:0] angle;
  logic signed [31:0] amount;
  logic signed [15:0] axis_ux;
  logic signed [15:0] axis_uy;
  logic signed [15:0] axis_uz;

  logic                     mat_ready;
  logic signed [MAT_W-1:0]  mat [9];
  logic                     en;
  logic                     v1;
  logic                     rot;
  mode_t                    mode [3];
  logic signed [W-1:0]      p [3];
  logic signed [W-1:0]      q [3];
  logic [2:0]               ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation   <= OP_ROT_AXIS;
      axis_select <= AX_X;
      angle       <= '0;
      amount      <= 32'sd65536;
      axis_ux     <= 16'sd16384;
      axis_uy     <= '0;
      axis_uz     <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        REG_OPERATION: operation   <= cfg_data[2:0];
        REG_AXIS_SEL:  axis_select <= cfg_data[1:0];
        REG_ANGLE:     angle       <= cfg_data[15:0];
        REG_AMOUNT:    amount      <= cfg_data;
        REG_AXIS_UX:   axis_ux     <= cfg_data[15:0];
        REG_AXIS_UY:   axis_uy     <= cfg_data[15:0];
        REG_AXIS_UZ:   axis_uz     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // matrix is rebuilt whenever any register changes
  ptd_matrix #(.STEPS(CORDIC_STEPS)) u_matrix (
    .clk         (clk),
    .rst         (rst),
    .kick        (cfg_wen),
    .operation   (operation),
    .axis_select (axis_select),
    .angle       (angle),
    .axis_ux     (axis_ux),
    .axis_uy     (axis_uy),
    .axis_uz     (axis_uz),
    .ready       (mat_ready),
    .mat         (mat)
  );

  // pipe moves when the output register is empty or taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = mat_ready && en;

  for (genvar g = 0; g < 3; g++) begin : g_in
    assign p[g] = s_tdata[g*W +: W];
  end

  // principal rotation with axis three passes the point
  assign rot = (operation == OP_ROT_AXIS) ||
               (operation == OP_ROT_PRIN && axis_select != AX_NONE);

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic signed [MAT_W-1:0] row [3];

    always_comb begin
      if (rot) begin
        mode[g] = MODE_ROT;
      end else if (operation == OP_TRANSLATE && axis_select == 2'(g)) begin
        mode[g] = MODE_ADD;
      end else if (operation == OP_MIRROR && axis_select == 2'(g)) begin
        mode[g] = MODE_NEG;
      end else if (operation == OP_SCALE) begin
        mode[g] = MODE_MUL;
      end else begin
        mode[g] = MODE_PASS;
      end
    end

    assign row[0] = mat[3*g];
    assign row[1] = mat[3*g+1];
    assign row[2] = mat[3*g+2];

    ptd_lane #(.W(W)) u_lane (
      .clk    (clk),
      .en     (en),
      .mode   (mode[g]),
      .row    (row),
      .p      (p),
      .p_self (p[g]),
      .amount (amount),
      .q      (q[g]),
      .ovf    (ovf[g])
    );
  end

  // merge of the three lanes into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1       <= s_tvalid && s_tready;
      m_tvalid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= OUT_W'({|ovf, q[2], q[1], q[0]});
    end
  end

`ifndef SYNTHESIS
  // a register write always drops input ready while the matrix is rebuilt
  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_wen |=> !s_tready) else $error("input accepted during matrix rebuild");

  // leaving reset, the matrix is not yet ready
  a_rst_stall: assert property (@(posedge clk)
    rst |=> !s_tready) else $error("input ready right after reset");

  // a stalled first stage keeps its item
  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !en |=> v1) else $error("pipeline item lost under stall");

  // overflow only with a saturated coordinate
  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3*W] |->
      (m_tdata[W-2:0] == '1 && !m_tdata[W-1]) || (m_tdata[W-2:0] == '0 && m_tdata[W-1]) ||
      (m_tdata[2*W-2:W] == '1 && !m_tdata[2*W-1]) ||
      (m_tdata[2*W-2:W] == '0 && m_tdata[2*W-1]) ||
      (m_tdata[3*W-2:2*W] == '1 && !m_tdata[3*W-1]) ||
      (m_tdata[3*W-2:2*W] == '0 && m_tdata[3*W-1]))
    else $error("overflow without saturated coordinate");
`endif

endmodule

// ===== tb/point_transform_3d_tb.sv =====
// point_transform_3d_tb: self-checking testbench of the 3d point transform
// depends on ptd_pkg and the point_transform_3d rtl; drives points through the
// stream ports, predicts every result in place and checks it as it leaves
`timescale 1ns / 100ps

module point_transform_3d_tb;
  import ptd_pkg::*;

  // codes beyond the named ones: passthrough cases of the block
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam logic [1:0] AX_NONE      = 2'd3;

  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam longint ONE_Q30   = 64'sd1073741824;
  localparam longint PI_Q30    = 64'sd3373259426;
  localparam longint HPI_Q30   = 64'sd1686629713;
  localparam longint GAIN_Q30  = 64'sd652032874;
  localparam int     TRIG_STEPS = 16;
  localparam int     STALL_LIMIT = 5000;

  // one transformed point as it should leave the block
  typedef struct {
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] qz;
    logic               ovf;
  } point_result_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [95:0]  s_tdata;   // px, py, pz from bit 0 up
  logic         m_tvalid;
  logic         m_tready;
  logic [103:0] m_tdata;   // qx, qy, qz, overflow from bit 0 up
  logic         cfg_wen;
  logic [2:0]   cfg_idx;
  logic [31:0]  cfg_data;

  point_transform_3d i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // shadow copy of the register file
  logic [2:0]         sh_op;
  logic [1:0]         sh_axis;
  logic signed [15:0] sh_angle;
  logic signed [31:0] sh_amount;
  logic signed [15:0] sh_ux, sh_uy, sh_uz;

  longint atan_tab [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  point_result_t pending_points[$];
  int  fail_count;
  int  stall_cycles;
  bit  idling_on;     // random gaps on both sides
  bit  hold_output;   // request for one long receiver hold-off

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint saturate(input longint v, inout bit ovf);
    if (v > COORD_MAX) begin
      ovf = 1'b1;
      return COORD_MAX;
    end
    if (v < COORD_MIN) begin
      ovf = 1'b1;
      return COORD_MIN;
    end
    return v;
  endfunction

  // fixed-step cordic; angles past +-pi/2 are folded back and the result negated
  function automatic void angle_sin_cos(output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit fold;
    z = longint'(sh_angle) * 131072;
    x = GAIN_Q30;
    y = 0;
    fold = 1'b0;
    if (z > HPI_Q30) begin
      z -= PI_Q30;
      fold = 1'b1;
    end else if (z < -HPI_Q30) begin
      z += PI_Q30;
      fold = 1'b1;
    end
    for (int i = 0; i < TRIG_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_tab[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_tab[i];
      end
    end
    c = fold ? -x : x;
    s = fold ? -y : y;
  endfunction

  function automatic point_result_t transform_point(input logic signed [31:0] px,
                                                    input logic signed [31:0] py,
                                                    input logic signed [31:0] pz);
    longint p[3], q[3], m[3][3], u[3];
    longint c, s, t, acc, e, amt, a_hi, a_lo;
    int a1, a2, ax;
    bit ovf;
    point_result_t r;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    q = p;
    ovf = 1'b0;
    ax = sh_axis;
    amt = sh_amount;
    if (sh_op == OP_ROT_AXIS || (sh_op == OP_ROT_PRIN && sh_axis != AX_NONE)) begin
      angle_sin_cos(c, s);
      if (sh_op == OP_ROT_AXIS) begin
        // rodrigues matrix of the configured axis
        u[0] = sh_ux;
        u[1] = sh_uy;
        u[2] = sh_uz;
        t = ONE_Q30 - c;
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            m[i][j] = (u[i] * u[j] * t) >>> 28;
        for (int i = 0; i < 3; i++)
          m[i][i] += c;
        m[0][1] -= (u[2] * s) >>> 14;
        m[1][0] += (u[2] * s) >>> 14;
        m[0][2] += (u[1] * s) >>> 14;
        m[2][0] -= (u[1] * s) >>> 14;
        m[1][2] -= (u[0] * s) >>> 14;
        m[2][1] += (u[0] * s) >>> 14;
      end else begin
        a1 = (ax + 1) % 3;
        a2 = (ax + 2) % 3;
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            m[i][j] = 0;
        m[ax][ax] = ONE_Q30;
        m[a1][a1] = c;
        m[a2][a2] = c;
        m[a1][a2] = -s;
        m[a2][a1] = s;
      end
      // entries clamped to [-1, +1]; with 32-bit coordinates all 30 fraction bits stay
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) begin
          e = m[i][j];
          if (e > ONE_Q30) e = ONE_Q30;
          if (e < -ONE_Q30) e = -ONE_Q30;
          acc += e * p[j];
        end
        q[i] = saturate(acc >>> 30, ovf);
      end
    end else if (sh_op == OP_TRANSLATE && sh_axis != AX_NONE) begin
      q[ax] = saturate(p[ax] + amt, ovf);
    end else if (sh_op == OP_MIRROR && sh_axis != AX_NONE) begin
      q[ax] = saturate(-p[ax], ovf);
    end else if (sh_op == OP_SCALE) begin
      a_hi = amt >>> 16;
      a_lo = amt & 64'hFFFF;
      for (int i = 0; i < 3; i++)
        q[i] = saturate(p[i] * a_hi + ((p[i] * a_lo) >>> 16), ovf);
    end
    r.qx = q[0][31:0];
    r.qy = q[1][31:0];
    r.qz = q[2][31:0];
    r.ovf = ovf;
    return r;
  endfunction

  // ------------------------------------------------------------ stimulus side

  // one register write; caller lowers cfg_wen once after its last write
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_wen  <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      REG_OPERATION: sh_op     = value[2:0];
      REG_AXIS_SEL:  sh_axis   = value[1:0];
      REG_ANGLE:     sh_angle  = value[15:0];
      REG_AMOUNT:    sh_amount = value;
      REG_AXIS_UX:   sh_ux     = value[15:0];
      REG_AXIS_UY:   sh_uy     = value[15:0];
      REG_AXIS_UZ:   sh_uz     = value[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // drain the pipe before any register changes
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [2:0] op, input logic [1:0] axis,
                            input logic [15:0] angle, input logic [31:0] amount,
                            input logic [15:0] ux, input logic [15:0] uy,
                            input logic [15:0] uz);
    wait_drained();
    write_reg(REG_OPERATION, 32'(op));
    write_reg(REG_AXIS_SEL,  32'(axis));
    write_reg(REG_ANGLE,     {{16{angle[15]}}, angle});
    write_reg(REG_AMOUNT,    amount);
    write_reg(REG_AXIS_UX,   {{16{ux[15]}}, ux});
    write_reg(REG_AXIS_UY,   {{16{uy[15]}}, uy});
    write_reg(REG_AXIS_UZ,   {{16{uz[15]}}, uz});
    cfg_wen <= 1'b0;
  endtask

  // offer one point and hold it until taken; s_tvalid stays high afterwards
  task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {pz, py, px};
    do @(posedge clk); while (!s_tready);
    pending_points.push_back(transform_point(px, py, pz));
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
      3: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_half();
    case ($urandom_range(0, 4))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------- the tests

  task automatic test_reset_values();
    // rotation about x by zero straight after reset, extremes of the coordinates
    send_point(32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
  endtask

  task automatic test_each_operation();
    logic [2:0] op;
    // principal rotation about each axis and the passthrough axis code
    for (int a = 0; a < 4; a++) begin
      set_config(OP_ROT_PRIN, 2'(a), 16'sd12868, 32'h0001_0000, 16'sd16384, 16'sd0,
                 16'sd0);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0003_0000);
    end
    // angles at both ends of the register, crossing the fold at +-pi/2
    set_config(OP_ROT_AXIS, AX_X, 16'h7FFF, 32'h0001_0000, 16'sd9459, 16'sd9459,
               16'sd9459);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    set_config(OP_ROT_AXIS, AX_X, 16'h8000, 32'h0001_0000, 16'sd0, 16'sd0, 16'sd16384);
    send_point(32'h8000_0000, 32'h0001_0000, 32'h8000_0000);
    // oversized axis makes entries leave [-1, +1] and get clamped
    set_config(OP_ROT_AXIS, AX_X, 16'sd8000, 32'h0001_0000, 16'h7FFF, 16'h8000,
               16'h7FFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
    // translation with the largest offsets of both signs
    set_config(OP_TRANSLATE, AX_Z, 16'sd0, 32'h7FFF_FFFF, 16'sd16384, 16'sd0, 16'sd0);
    send_point(32'h0, 32'h0, 32'h0000_0001);
    set_config(OP_TRANSLATE, AX_Y, 16'sd0, 32'h8000_0000, 16'sd16384, 16'sd0, 16'sd0);
    send_point(32'h0, 32'hFFFF_FFFF, 32'h0);
    // mirror of the most negative value saturates
    set_config(OP_MIRROR, AX_X, 16'sd0, 32'h0001_0000, 16'sd16384, 16'sd0, 16'sd0);
    send_point(32'h8000_0000, 32'h1, 32'h2);
    send_point(32'h7FFF_FFFF, 32'h1, 32'h2);
    set_config(OP_MIRROR, AX_NONE, 16'sd0, 32'h0001_0000, 16'sd16384, 16'sd0, 16'sd0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    // scaling by the most negative factor and by a pure fraction
    set_config(OP_SCALE, AX_X, 16'sd0, 32'h8000_0000, 16'sd16384, 16'sd0, 16'sd0);
    send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    set_config(OP_SCALE, AX_X, 16'sd0, 32'h0000_FFFF, 16'sd16384, 16'sd0, 16'sd0);
    send_point(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    // unused operation codes leave the point alone
    for (op = OP_UNUSED_LO; op <= OP_UNUSED_HI && op != 3'd0; op++) begin
      set_config(op, AX_Y, 16'sd1000, 32'h7FFF_FFFF, 16'sd16384, 16'sd0, 16'sd0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_AAAA);
    end
  endtask

  task automatic random_config();
    logic [2:0] op;
    logic [31:0] amount;
    case ($urandom_range(0, 9))
      0, 1, 2: op = OP_ROT_AXIS;
      3, 4:    op = OP_ROT_PRIN;
      5:       op = OP_TRANSLATE;
      6:       op = OP_MIRROR;
      7, 8:    op = OP_SCALE;
      default: op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    endcase
    case ($urandom_range(0, 3))
      0: amount = $urandom;
      1: amount = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: amount = 32'($signed($urandom_range(0, 1048576)) - 524288);
    endcase
    set_config(op, 2'($urandom_range(0, 3)), pick_half(), amount, pick_half(),
               pick_half(), pick_half());
  endtask

  task automatic test_random_phases(input int phases, input int per_phase);
    for (int k = 0; k < phases; k++) begin
      random_config();
      repeat (per_phase) send_point(pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  // receiver holds off while the sender keeps offering, so the block fills and stalls
  task automatic test_output_hold();
    set_config(OP_SCALE, AX_X, 16'sd0, 32'h0002_8000, 16'sd16384, 16'sd0, 16'sd0);
    hold_output = 1'b1;
    repeat (40) send_point(pick_coord(), pick_coord(), pick_coord());
  endtask

  // ------------------------------------------------------------ receive side

  initial begin
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_output) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_output = 1'b0;
        m_tready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    point_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_points.size() == 0) begin
        $error("result with no point pending: %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_points.pop_front();
        if (m_tdata[31:0] !== want.qx) begin
          $error("qx expected %h actual %h", want.qx, m_tdata[31:0]);
          fail_count++;
        end
        if (m_tdata[63:32] !== want.qy) begin
          $error("qy expected %h actual %h", want.qy, m_tdata[63:32]);
          fail_count++;
        end
        if (m_tdata[95:64] !== want.qz) begin
          $error("qz expected %h actual %h", want.qz, m_tdata[95:64]);
          fail_count++;
        end
        if (m_tdata[96] !== want.ovf) begin
          $error("overflow expected %b actual %b", want.ovf, m_tdata[96]);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ------------------------------------------------------------------ main

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_wen = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    fail_count = 0;
    stall_cycles = 0;
    idling_on = 1'b1;
    hold_output = 1'b0;
    // reset values of the registers
    sh_op = OP_ROT_AXIS;
    sh_axis = AX_X;
    sh_angle = 16'sd0;
    sh_amount = 32'sd65536;
    sh_ux = 16'sd16384;
    sh_uy = 16'sd0;
    sh_uz = 16'sd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_each_operation();
    test_random_phases(14, 100);
    test_output_hold();
    // last stretch runs at full rate on both sides
    wait_drained();
    idling_on = 1'b0;
    test_random_phases(4, 100);

    s_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ptd_pkg.sv
rtl/core/ptd_cordic.sv
rtl/core/ptd_matrix.sv
rtl/core/ptd_lane.sv
rtl/core/point_transform_3d.sv
tb/point_transform_3d_tb.sv
